// File: rtl/core/bracket_nesting_checker_defines.svh
// ----------------------------------------------------------------------------
// Bracket nesting checker assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BRACKET_NESTING_CHECKER_DEFINES_SVH
`define BRACKET_NESTING_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define BNC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bnc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker package
// Status codes, bracket characters, decode functions and control structs.
// ----------------------------------------------------------------------------
package bnc_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [7:0] CH_LROUND  = 8'h28;
    localparam logic [7:0] CH_RROUND  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } t_bracket;

    typedef struct packed {
        logic exec;
        logic refill;
    } t_dp_cmd;

    typedef struct packed {
        logic pop;
        logic out_free;
    } t_dp_sts;

    function automatic t_bracket decode_opener(input logic [7:0] ch);
        t_bracket res;
        res.hit  = 1'b1;
        res.kind = KIND_ROUND;
        case (ch)
            CH_LROUND:  res.kind = KIND_ROUND;
            CH_LSQUARE: res.kind = KIND_SQUARE;
            CH_LCURLY:  res.kind = KIND_CURLY;
            CH_LANGLE:  res.kind = KIND_ANGLE;
            default:    res.hit  = 1'b0;
        endcase
        return res;
    endfunction

    function automatic t_bracket decode_closer(input logic [7:0] ch);
        t_bracket res;
        res.hit  = 1'b1;
        res.kind = KIND_ROUND;
        case (ch)
            CH_RROUND:  res.kind = KIND_ROUND;
            CH_RSQUARE: res.kind = KIND_SQUARE;
            CH_RCURLY:  res.kind = KIND_CURLY;
            CH_RANGLE:  res.kind = KIND_ANGLE;
            default:    res.hit  = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/bnc_datapath.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker datapath
// Kind stack memory, top-of-stack register, depth and status, result register.
// ----------------------------------------------------------------------------
`include "bracket_nesting_checker_defines.svh"

module bnc_datapath
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_is_bracket,
    input  logic [7:0] i_token_char,
    input  logic       i_last_token,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [1:0] o_status,
    output logic [6:0] o_nest_depth,
    output logic       o_list_end,
    output logic       o_balanced
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [1:0]    r_stack [STACK_DEPTH];
    logic [1:0]    r_rd_data;
    logic [1:0]    r_top;
    logic [1:0]    n_top;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    r_err;
    logic [1:0]    n_err;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [1:0]    r_status;
    logic [6:0]    r_nest_depth;
    logic          r_list_end;
    logic          r_balanced;

    t_bracket      opener;
    t_bracket      closer;
    logic          wr_en;
    logic          pop;
    logic [CW-1:0] res_count;
    logic [1:0]    res_err;
    logic [AW-1:0] rd_addr;

    assign opener  = decode_opener(i_token_char);
    assign closer  = decode_closer(i_token_char);
    assign rd_addr = AW'(r_count - CW'(2));

    always_comb begin
        res_count = r_count;
        res_err   = r_err;
        n_top     = r_top;
        wr_en     = 1'b0;
        pop       = 1'b0;
        if (i_cmd.exec && i_is_bracket && (r_err == ST_OK)) begin
            if (opener.hit) begin
                if (r_count == CW'(STACK_DEPTH)) begin
                    res_err = ST_OVERFLOW;
                end else begin
                    wr_en     = 1'b1;
                    res_count = r_count + CW'(1);
                    n_top     = opener.kind;
                end
            end else if (closer.hit) begin
                if ((r_count == '0) || (r_top != closer.kind)) begin
                    res_err = ST_MISMATCH;
                end else begin
                    pop       = 1'b1;
                    res_count = r_count - CW'(1);
                end
            end
        end
        if (i_cmd.refill) begin
            n_top = r_rd_data;
        end
        n_count = res_count;
        n_err   = res_err;
        if (i_cmd.exec && i_last_token) begin
            n_count = '0;
            n_err   = ST_OK;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[r_count[AW-1:0]] <= opener.kind;
        end
        r_rd_data <= r_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (i_cmd.exec) begin
            r_status     <= res_err;
            r_nest_depth <= 7'(res_count);
            r_list_end   <= i_last_token;
            r_balanced   <= i_last_token && (res_err == ST_OK) && (res_count == '0);
        end
    end

    assign o_sts.pop      = pop;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_nest_depth = r_nest_depth;
    assign o_list_end   = r_list_end;
    assign o_balanced   = r_balanced;

    `BNC_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(STACK_DEPTH), "Stack count exceeds depth.")
    `BNC_ASSERT_NEXT(a_clear_on_last, i_cmd.exec && i_last_token, (r_count == '0) && (r_err == ST_OK), "State not cleared after last token.")
    `BNC_ASSERT_NEXT(a_err_sticky, (r_err != ST_OK) && !(i_cmd.exec && i_last_token), r_err == $past(r_err), "Error status changed before list end.")
    `BNC_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_out_ready, !i_cmd.exec, "Pending result overwritten.")

endmodule

// File: rtl/core/bnc_controller.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker controller
// Accepts tokens and schedules the stack-top refill after a pop.
// ----------------------------------------------------------------------------
module bnc_controller
    import bnc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REFILL = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready   = (r_state == S_IDLE) && i_sts.out_free;
    assign o_cmd.exec   = i_in_valid && o_in_ready;
    assign o_cmd.refill = (r_state == S_REFILL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.exec && i_sts.pop) begin
                    n_state = S_REFILL;
                end
            end
            S_REFILL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/bracket_nesting_checker.sv
// ----------------------------------------------------------------------------
// Bracket nesting checker
// Checks that bracket tokens of a token list nest correctly.
// ----------------------------------------------------------------------------
// One token enters per input transaction (i_in_valid / o_in_ready) and one
// result leaves per output transaction (o_out_valid / i_out_ready).
// Each result carries the sticky status, the nesting depth after the token,
// the list-end echo and, on the last token, the balanced flag.
// The result is registered and appears in the cycle after the token is accepted.
// A closing bracket that pops the stack holds off the next token while the new
// top of stack is read from the synchronous stack memory; other tokens do not.
// A finished result may wait in the output register while the next token is
// accepted, as long as the receiver takes it in the same cycle.
// When the receiver stalls with a result pending, o_in_ready stays low.
// Reset clears the depth, the status and any pending result; the stack
// memory needs no clearing since only entries below the depth are read.
// After the last token of a list the depth and status return to zero.
// ----------------------------------------------------------------------------
module bracket_nesting_checker
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_is_bracket,
    input  logic [7:0] i_token_char,
    input  logic       i_last_token,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [6:0] o_nest_depth,
    output logic       o_list_end,
    output logic       o_balanced
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bnc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bnc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_is_bracket (i_is_bracket),
        .i_token_char (i_token_char),
        .i_last_token (i_last_token),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_nest_depth (o_nest_depth),
        .o_list_end   (o_list_end),
        .o_balanced   (o_balanced)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket nesting checker testbench
// A queue-fed driver offers token lists to the checker and a monitor compares
// every result transaction, field by field, with a nesting tracker kept in
// step with the accepted tokens. Short directed lists come first, then random
// lists, mostly well formed with mixed noise, over four idling phases. One
// long receiver hold-off fills the block, and the sender drains between
// phases.
// ----------------------------------------------------------------------------
module tb_top
    import bnc_pkg::*;
();

    localparam int STACK_DEPTH = 64;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic       br;
        logic [7:0] ch;
        logic       last;
    } t_token;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] depth;
        logic       list_end;
        logic       balanced;
    } t_nesting;

    typedef enum {
        PH_NONE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_phase;

    typedef enum {
        LIST_CLEAN,
        LIST_WRONG_KIND,
        LIST_EXTRA_CLOSE,
        LIST_UNCLOSED,
        LIST_NOISE,
        LIST_FULL,
        LIST_OVERFLOW
    } t_list;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       i_is_bracket = 1'b0;
    logic [7:0] i_token_char = 8'h00;
    logic       i_last_token = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_status;
    logic [6:0] o_nest_depth;
    logic       o_list_end;
    logic       o_balanced;

    t_token   token_backlog[$];
    t_nesting awaited_results[$];

    logic [1:0] kind_stack[STACK_DEPTH];
    int         open_cnt  = 0;
    logic [1:0] sticky_st = ST_OK;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   queued_total   = 0;
    int   mismatch_cnt   = 0;
    logic hold_arm       = 1'b0;
    logic hold_used      = 1'b0;
    int   hold_left      = 0;

    bracket_nesting_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_is_bracket (i_is_bracket),
        .i_token_char (i_token_char),
        .i_last_token (i_last_token),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_nest_depth (o_nest_depth),
        .o_list_end   (o_list_end),
        .o_balanced   (o_balanced)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_nesting next_nesting_result(input logic br, input logic [7:0] ch,
                                                     input logic last);
        t_nesting   res;
        logic       opens;
        logic       closes;
        logic [1:0] kind;
        opens  = 1'b0;
        closes = 1'b0;
        kind   = KIND_ROUND;
        case (ch)
            CH_LROUND:  begin opens  = 1'b1; kind = KIND_ROUND;  end
            CH_LSQUARE: begin opens  = 1'b1; kind = KIND_SQUARE; end
            CH_LCURLY:  begin opens  = 1'b1; kind = KIND_CURLY;  end
            CH_LANGLE:  begin opens  = 1'b1; kind = KIND_ANGLE;  end
            CH_RROUND:  begin closes = 1'b1; kind = KIND_ROUND;  end
            CH_RSQUARE: begin closes = 1'b1; kind = KIND_SQUARE; end
            CH_RCURLY:  begin closes = 1'b1; kind = KIND_CURLY;  end
            CH_RANGLE:  begin closes = 1'b1; kind = KIND_ANGLE;  end
            default: ;
        endcase
        if (br && sticky_st == ST_OK) begin
            if (opens) begin
                if (open_cnt >= STACK_DEPTH) begin
                    sticky_st = ST_OVERFLOW;
                end else begin
                    kind_stack[open_cnt] = kind;
                    open_cnt++;
                end
            end else if (closes) begin
                if (open_cnt == 0) begin
                    sticky_st = ST_MISMATCH;
                end else if (kind_stack[open_cnt - 1] != kind) begin
                    sticky_st = ST_MISMATCH;
                end else begin
                    open_cnt--;
                end
            end
        end
        res.status   = sticky_st;
        res.depth    = 7'(open_cnt);
        res.list_end = last;
        res.balanced = last && sticky_st == ST_OK && open_cnt == 0;
        if (last) begin
            open_cnt  = 0;
            sticky_st = ST_OK;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : driver
        t_token tok;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            open_cnt  = 0;
            sticky_st = ST_OK;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(
                    next_nesting_result(i_is_bracket, i_token_char, i_last_token));
            end
            if (!i_in_valid || o_in_ready) begin
                if (token_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    tok = token_backlog.pop_front();
                    i_in_valid   <= 1'b1;
                    i_is_bracket <= tok.br;
                    i_token_char <= tok.ch;
                    i_last_token <= tok.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver_hold
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic report_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_nesting want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got status %0d depth %0d",
                             $time, o_status, o_nest_depth);
                    mismatch_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    report_field("status", int'(want.status), int'(o_status));
                    report_field("nest_depth", int'(want.depth), int'(o_nest_depth));
                    report_field("list_end", int'(want.list_end), int'(o_list_end));
                    report_field("balanced", int'(want.balanced), int'(o_balanced));
                end
            end
            i_out_ready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic push_tok(input logic br, input logic [7:0] ch, input logic last);
        t_token tok;
        tok.br   = br;
        tok.ch   = ch;
        tok.last = last;
        token_backlog.push_back(tok);
        queued_total++;
    endtask

    function automatic logic [7:0] opener_char(input logic [1:0] kind);
        case (kind)
            KIND_ROUND:  return CH_LROUND;
            KIND_SQUARE: return CH_LSQUARE;
            KIND_CURLY:  return CH_LCURLY;
            default:     return CH_LANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input logic [1:0] kind);
        case (kind)
            KIND_ROUND:  return CH_RROUND;
            KIND_SQUARE: return CH_RSQUARE;
            KIND_CURLY:  return CH_RCURLY;
            default:     return CH_RANGLE;
        endcase
    endfunction

    function automatic t_token bracket_tok(input logic [7:0] ch);
        t_token tok;
        tok.br   = 1'b1;
        tok.ch   = ch;
        tok.last = 1'b0;
        return tok;
    endfunction

    function automatic logic [7:0] any_bracket_char();
        logic [1:0] kind;
        kind = 2'($urandom_range(3));
        return $urandom_range(1) ? opener_char(kind) : closer_char(kind);
    endfunction

    function automatic t_token noise_tok();
        t_token tok;
        tok.last = 1'b0;
        tok.br   = 1'($urandom_range(1));
        tok.ch   = 8'($urandom_range(255));
        while (tok.br && (tok.ch == CH_LROUND || tok.ch == CH_RROUND ||
                          tok.ch == CH_LSQUARE || tok.ch == CH_RSQUARE ||
                          tok.ch == CH_LCURLY || tok.ch == CH_RCURLY ||
                          tok.ch == CH_LANGLE || tok.ch == CH_RANGLE)) begin
            tok.ch = 8'($urandom_range(255));
        end
        return tok;
    endfunction

    task automatic make_list(input t_list flavor, input int steps, input int nest_cap);
        logic [1:0] open_kinds[$];
        t_token     toks[$];
        t_token     tok;
        logic [1:0] kind;
        int         pick;
        for (int s = 0; s < steps; s++) begin
            pick = $urandom_range(99);
            if (flavor == LIST_NOISE) begin
                tok    = noise_tok();
                tok.br = 1'($urandom_range(1));
                if ($urandom_range(1)) begin
                    tok.ch = any_bracket_char();
                end
                toks.push_back(tok);
            end else if (pick < 40 && open_kinds.size() < nest_cap) begin
                kind = 2'($urandom_range(3));
                open_kinds.push_back(kind);
                toks.push_back(bracket_tok(opener_char(kind)));
            end else if (pick < 80 && open_kinds.size() > 0) begin
                toks.push_back(bracket_tok(closer_char(open_kinds.pop_back())));
            end else begin
                toks.push_back(noise_tok());
            end
        end
        case (flavor)
            LIST_FULL, LIST_OVERFLOW: begin
                while (open_kinds.size() < STACK_DEPTH) begin
                    kind = 2'($urandom_range(3));
                    open_kinds.push_back(kind);
                    toks.push_back(bracket_tok(opener_char(kind)));
                    if ($urandom_range(9) == 0) begin
                        toks.push_back(noise_tok());
                    end
                end
                if (flavor == LIST_OVERFLOW) begin
                    toks.push_back(bracket_tok(opener_char(2'($urandom_range(3)))));
                    toks.push_back(bracket_tok(closer_char(open_kinds[$])));
                end
            end
            LIST_WRONG_KIND: begin
                kind = open_kinds.size() > 0 ? open_kinds[$] : 2'($urandom_range(3));
                toks.push_back(bracket_tok(closer_char(kind + 2'($urandom_range(1, 3)))));
            end
            LIST_EXTRA_CLOSE: begin
                while (open_kinds.size() > 0) begin
                    toks.push_back(bracket_tok(closer_char(open_kinds.pop_back())));
                end
                toks.push_back(bracket_tok(closer_char(2'($urandom_range(3)))));
            end
            LIST_UNCLOSED: begin
                if (open_kinds.size() == 0) begin
                    toks.push_back(bracket_tok(opener_char(2'($urandom_range(3)))));
                end
            end
            default: ;
        endcase
        if (flavor == LIST_CLEAN || flavor == LIST_FULL) begin
            while (open_kinds.size() > 0) begin
                toks.push_back(bracket_tok(closer_char(open_kinds.pop_back())));
            end
        end else if (flavor != LIST_NOISE) begin
            repeat ($urandom_range(3)) toks.push_back(bracket_tok(any_bracket_char()));
        end
        if (toks.size() > 0 && $urandom_range(1)) begin
            tok = toks.pop_back();
        end else begin
            tok = noise_tok();
        end
        tok.last = 1'b1;
        toks.push_back(tok);
        foreach (toks[i]) begin
            push_tok(toks[i].br, toks[i].ch, toks[i].last);
        end
    endtask

    task automatic run_phase(input t_phase ph);
        int    goal;
        int    pick;
        t_list flavor;
        case (ph)
            PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PH_SEND_IDLE:  begin send_idle_pct = 56; recv_stall_pct = 0;  end
            PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
        goal = queued_total + 250;
        if (ph == PH_NONE) begin
            push_tok(1'b1, CH_RROUND, 1'b0);
            push_tok(1'b1, CH_LROUND, 1'b0);
            push_tok(1'b0, 8'hFF, 1'b1);
            push_tok(1'b1, CH_LROUND, 1'b0);
            push_tok(1'b1, CH_LSQUARE, 1'b0);
            push_tok(1'b1, CH_LCURLY, 1'b0);
            push_tok(1'b1, CH_LANGLE, 1'b0);
            push_tok(1'b1, CH_RANGLE, 1'b0);
            push_tok(1'b1, CH_RCURLY, 1'b0);
            push_tok(1'b1, CH_RSQUARE, 1'b0);
            push_tok(1'b1, CH_RROUND, 1'b1);
            push_tok(1'b1, CH_LSQUARE, 1'b0);
            push_tok(1'b1, CH_RROUND, 1'b0);
            push_tok(1'b1, CH_RSQUARE, 1'b0);
            push_tok(1'b0, 8'h00, 1'b1);
            push_tok(1'b1, CH_LCURLY, 1'b0);
            push_tok(1'b1, CH_LANGLE, 1'b1);
            push_tok(1'b0, CH_LROUND, 1'b0);
            push_tok(1'b1, 8'h00, 1'b0);
            push_tok(1'b1, 8'hFF, 1'b1);
            push_tok(1'b0, 8'h00, 1'b1);
            push_tok(1'b1, CH_RSQUARE, 1'b1);
        end else if (ph == PH_SEND_IDLE) begin
            make_list(LIST_FULL, 0, 0);
        end else if (ph == PH_RECV_STALL) begin
            hold_arm = 1'b1;
            make_list(LIST_OVERFLOW, 0, 0);
        end else begin
            make_list(LIST_OVERFLOW, 12, 6);
        end
        while (queued_total < goal) begin
            pick   = $urandom_range(99);
            flavor = pick < 60 ? LIST_CLEAN :
                     pick < 68 ? LIST_WRONG_KIND :
                     pick < 76 ? LIST_EXTRA_CLOSE :
                     pick < 86 ? LIST_UNCLOSED : LIST_NOISE;
            make_list(flavor, $urandom_range(0, 24), $urandom_range(1, 12));
        end
        while (token_backlog.size() != 0 || i_in_valid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_phase(PH_NONE);
        run_phase(PH_SEND_IDLE);
        run_phase(PH_RECV_STALL);
        run_phase(PH_BOTH);
        repeat (16) @(negedge i_clk);
        if (awaited_results.size() != 0) begin
            $display("%0t ns: results outstanding, expected 0, got %0d",
                     $time, awaited_results.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
